// ----- rtl/krce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_pkg
// Event word formats and queue status type shared by the report change
// encoder modules.
// ----------------------------------------------------------------------------
package krce_pkg;

	localparam int CODE_W = 8;
	localparam int WORD_W = 16;

	localparam logic [2:0] MOD_START = 3'b110;
	localparam logic [2:0] MOD_STOP  = 3'b010;
	localparam logic [2:0] KEY_START = 3'b101;
	localparam logic [2:0] KEY_STOP  = 3'b011;

	typedef struct packed {
		logic full;
		logic empty;
	} krce_qstat_t;

	function automatic logic [WORD_W-1:0] mod_word(input logic [CODE_W-1:0] mods);
		return {MOD_START, 1'b0, mods, MOD_STOP, 1'b0};
	endfunction

	function automatic logic [WORD_W-1:0] key_word(input logic press,
			input logic [CODE_W-1:0] code);
		return {KEY_START, press, code, KEY_STOP, press};
	endfunction

endpackage

// ----- rtl/krce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_front
// Accepts reports, compares them with the stored previous report and
// queues one descriptor of all the events that the report causes, if any.
// ----------------------------------------------------------------------------
module krce_front
	import krce_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// modifier_bits, key_slot_0 .. key_slot_N-1
	input  logic [CODE_W*(KEY_SLOTS+1)-1:0]      s_tdata,
	input  krce_qstat_t                          qstat,
	output logic                                 push,
	output logic [2*KEY_SLOTS+1+CODE_W*(2*KEY_SLOTS+1)-1:0] push_data
);

	localparam int MASK_W = 2*KEY_SLOTS + 1;

	logic [CODE_W-1:0] prev_mod_q;
	logic [CODE_W-1:0] prev_keys_q [KEY_SLOTS];
	logic [CODE_W-1:0] mods;
	logic [CODE_W-1:0] keys [KEY_SLOTS];
	logic [KEY_SLOTS-1:0] release_v;
	logic [KEY_SLOTS-1:0] press_v;
	logic [MASK_W-1:0] mask;
	logic [CODE_W*KEY_SLOTS-1:0] prev_flat;
	logic accept;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;
	assign mods     = s_tdata[CODE_W-1:0];

	always_comb begin
		logic held_new;
		logic held_old;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			keys[i] = s_tdata[CODE_W*(i+1) +: CODE_W];
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			held_new = 1'b0;
			held_old = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				held_new = held_new | (keys[j] == prev_keys_q[i]);
				held_old = held_old | (prev_keys_q[j] == keys[i]);
			end
			release_v[i] = (prev_keys_q[i] != '0) && !held_new;
			press_v[i]   = (keys[i] != '0) && !held_old;
			prev_flat[CODE_W*i +: CODE_W] = prev_keys_q[i];
		end
	end

	assign mask      = {press_v, release_v, mods != prev_mod_q};
	assign push      = accept && (mask != '0);
	assign push_data = {mask, mods, prev_flat, s_tdata[CODE_W*(KEY_SLOTS+1)-1:CODE_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mod_q <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= '0;
			end
		end else if (accept) begin
			prev_mod_q <= mods;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= keys[i];
			end
		end
	end

endmodule

// ----- rtl/krce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_queue
// Short first-in first-out queue of event descriptors between the front
// and the back part.
// ----------------------------------------------------------------------------
module krce_queue
	import krce_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output krce_qstat_t      qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/krce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_back
// Takes event descriptors from the queue and sends one event word per
// cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module krce_back
	import krce_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  krce_qstat_t                          qstat,
	input  logic [2*KEY_SLOTS+1+CODE_W*(2*KEY_SLOTS+1)-1:0] pop_data,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// event_word
	output logic [WORD_W-1:0]                    m_tdata,
	output logic                                 m_tlast
);

	localparam int MASK_W = 2*KEY_SLOTS + 1;
	localparam int KB_W   = CODE_W*KEY_SLOTS;

	logic [MASK_W-1:0] mask_q;
	logic [CODE_W-1:0] mod_q;
	logic [KB_W-1:0]   prev_q;
	logic [KB_W-1:0]   new_q;
	logic [MASK_W-1:0] sel;
	logic [MASK_W-1:0] rest;
	logic [MASK_W-1:0] next_mask;
	logic [WORD_W-1:0] word;
	logic              adv;
	logic              valid_q;
	logic [WORD_W-1:0] data_q;
	logic              last_q;

	assign sel       = mask_q & (~mask_q + 1'b1);
	assign rest      = mask_q & ~sel;
	assign adv       = (mask_q != '0) && (!valid_q || m_tready);
	assign next_mask = adv ? rest : mask_q;
	assign pop       = (next_mask == '0) && !qstat.empty;

	always_comb begin
		word = sel[0] ? mod_word(mod_q) : '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (sel[1+i]) begin
				word = word | key_word(1'b0, prev_q[CODE_W*i +: CODE_W]);
			end
			if (sel[1+KEY_SLOTS+i]) begin
				word = word | key_word(1'b1, new_q[CODE_W*i +: CODE_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			mask_q <= pop ? pop_data[MASK_W+CODE_W+2*KB_W-1 -: MASK_W] : next_mask;
			if (adv) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mod_q  <= pop_data[2*KB_W +: CODE_W];
			prev_q <= pop_data[KB_W +: KB_W];
			new_q  <= pop_data[KB_W-1:0];
		end
		if (adv) begin
			data_q <= word;
			last_q <= (rest == '0);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/keyboard_report_change_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_change_encoder
// Compares each keyboard report with the previous one and sends a run of
// 16-bit modifier, release and press event words.
// ----------------------------------------------------------------------------
// The first event word of a report passes the queue, the back part's mask register and
// the output register. The output stage sends one event word per cycle while the
// receiver is ready; a report causes at most 2*KEY_SLOTS+1 words.
// The front takes one report per cycle while the two-entry queue has room.
// Reset clears the stored previous report to zero and empties queue and output.
// ----------------------------------------------------------------------------
module keyboard_report_change_encoder
	import krce_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// modifier_bits, key_slot_0 .. key_slot_N-1
	input  logic [CODE_W*(KEY_SLOTS+1)-1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// event_word
	output logic [WORD_W-1:0]               m_tdata,
	// last_of_run
	output logic                            m_tlast
);

	localparam int ENTRY_W = 2*KEY_SLOTS + 1 + CODE_W*(2*KEY_SLOTS + 1);

	krce_qstat_t        qstat;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] pop_data;

	krce_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	krce_queue #(.WIDTH(ENTRY_W), .DEPTH(2)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	krce_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_word_format: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[15:13] == MOD_START && m_tdata[3:1] == MOD_STOP &&
			!m_tdata[12] && !m_tdata[0]) ||
			(m_tdata[15:13] == KEY_START && m_tdata[3:1] == KEY_STOP &&
			m_tdata[12] == m_tdata[0])))
		else $error("malformed event word");

	a_mod_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			!(m_tvalid && m_tdata[15:13] == MOD_START))
		else $error("modifier word inside a run");

endmodule

// ----- sim/keyboard_report_change_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_change_encoder_tb
// Sends boot keyboard reports into the encoder and checks every event word
// and its last flag. The checks use an internal model of the report history.
// A directed table covers the extremes, an unchanged report, duplicate slots,
// empty slots and a run of maximum length. A random phase follows. It mostly
// lets held reports evolve slot by slot, and it mixes in repeats and fully
// random reports. Both stream sides pause at random.
// ----------------------------------------------------------------------------
module keyboard_report_change_encoder_tb;
	import krce_pkg::*;

	localparam int SLOTS        = 6;
	localparam int MAX_RUN      = 2*SLOTS + 1;
	localparam int KEYS_W       = CODE_W*SLOTS;
	localparam int RANDOM_ITEMS = 415;
	localparam int HOLD_ITEM    = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} event_t;

	typedef struct packed {
		logic [CODE_W-1:0] mods;
		logic [KEYS_W-1:0] keys;
		bit                typed;
		logic [1:0]        n;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [CODE_W*(SLOTS+1)-1:0] s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [WORD_W-1:0]        m_tdata;
	logic                     m_tlast;

	event_t            pending_events[$];
	stim_row_t         directed[$];
	logic [CODE_W-1:0] held_mods;
	logic [KEYS_W-1:0] held_keys;
	int                errors = 0;
	int                cycle_count = 0;
	bit                idle_on;

	keyboard_report_change_encoder #(
		.KEY_SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d event words outstanding", $time,
			pending_events.size());
		$display("** keyboard_report_change_encoder: FAILED **");
		$finish;
	end

	function automatic logic [KEYS_W-1:0] slots(input logic [CODE_W-1:0] k0, k1, k2,
			k3, k4, k5);
		return {k5, k4, k3, k2, k1, k0};
	endfunction

	function automatic bit slot_match(input logic [KEYS_W-1:0] keys,
			input logic [CODE_W-1:0] code);
		int i;
		for (i = 0; i < SLOTS; i++) begin
			if (keys[i*CODE_W +: CODE_W] == code) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Builds the event run of one report and moves the held report forward.
	function automatic int encode_change(input logic [CODE_W-1:0] mods,
			input logic [KEYS_W-1:0] keys, output logic [MAX_RUN*WORD_W-1:0] words);
		int n;
		int i;
		logic [CODE_W-1:0] code;
		n = 0;
		words = '0;
		if (mods != held_mods) begin
			words[n*WORD_W +: WORD_W] = {MOD_START, 1'b0, mods, MOD_STOP, 1'b0};
			n++;
		end
		for (i = 0; i < SLOTS; i++) begin
			code = held_keys[i*CODE_W +: CODE_W];
			if (code != 0 && !slot_match(keys, code)) begin
				words[n*WORD_W +: WORD_W] = {KEY_START, 1'b0, code, KEY_STOP, 1'b0};
				n++;
			end
		end
		for (i = 0; i < SLOTS; i++) begin
			code = keys[i*CODE_W +: CODE_W];
			if (code != 0 && !slot_match(held_keys, code)) begin
				words[n*WORD_W +: WORD_W] = {KEY_START, 1'b1, code, KEY_STOP, 1'b1};
				n++;
			end
		end
		held_mods = mods;
		held_keys = keys;
		return n;
	endfunction

	task automatic send_report(input stim_row_t row);
		int gap;
		int n;
		int k;
		event_t ev;
		logic [MAX_RUN*WORD_W-1:0] words;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.keys, row.mods};
		do @(posedge clk); while (!s_tready);
		n = encode_change(row.mods, row.keys, words);
		if (row.typed) begin
			n = row.n;
			words = '0;
			words[WORD_W-1:0] = row.w0;
			words[2*WORD_W-1:WORD_W] = row.w1;
		end
		for (k = 0; k < n; k++) begin
			ev.word = words[k*WORD_W +: WORD_W];
			ev.last = (k == n - 1);
			pending_events.push_back(ev);
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_events
		event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event word, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (m_tdata !== want.word) begin
					$display("%0t: event word mismatch, expected %h, actual %h",
						$time, want.word, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last flag mismatch, expected %b, actual %b",
						$time, want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin : sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin : source
		stim_row_t row;
		logic [CODE_W-1:0] cur_mods;
		logic [KEYS_W-1:0] cur_keys;
		int item;
		int i;
		int pick;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		idle_on     = 1'b1;
		held_mods   = '0;
		held_keys   = '0;

		// The encoder starts from an all-zero held report.
		directed.push_back('{8'h00, slots(0, 0, 0, 0, 0, 0), 1, 0, 16'h0, 16'h0});
		directed.push_back('{8'hFF, slots(0, 0, 0, 0, 0, 0), 1, 1, 16'hCFF4, 16'h0});
		directed.push_back('{8'hFF, slots(8'hFF, 0, 0, 0, 0, 0), 1, 1, 16'hBFF7, 16'h0});
		directed.push_back('{8'h00, slots(0, 0, 0, 0, 0, 0), 1, 2, 16'hC004, 16'hAFF6});
		directed.push_back('{8'h00, slots(1, 2, 3, 4, 5, 6), 0, 0, 16'h0, 16'h0});
		directed.push_back('{8'h00, slots(1, 2, 3, 4, 5, 6), 1, 0, 16'h0, 16'h0});
		directed.push_back('{8'h00, slots(6, 5, 4, 3, 2, 1), 1, 0, 16'h0, 16'h0});
		directed.push_back('{8'h81, slots(7, 8, 9, 10, 11, 12), 0, 0, 16'h0, 16'h0});
		directed.push_back('{8'h81, slots(4, 4, 4, 0, 0, 0), 0, 0, 16'h0, 16'h0});
		directed.push_back('{8'h81, slots(4, 0, 0, 0, 0, 0), 1, 0, 16'h0, 16'h0});
		directed.push_back('{8'h81, slots(0, 0, 0, 0, 0, 4), 1, 0, 16'h0, 16'h0});
		directed.push_back('{8'h55, slots(8'h55, 8'hAA, 0, 8'h55, 0, 0), 0, 0, 16'h0,
			16'h0});
		directed.push_back('{8'h55, slots(8'hAA, 8'h55, 0, 0, 0, 0), 1, 0, 16'h0, 16'h0});
		directed.push_back('{8'hAA, slots(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, 0,
			16'h0, 16'h0});
		directed.push_back('{8'hAA, slots(0, 0, 0, 0, 0, 0), 0, 0, 16'h0, 16'h0});
		directed.push_back('{8'h7F, slots(8'h80, 8'h01, 8'h7F, 8'hFE, 8'h40, 8'hBF), 0, 0,
			16'h0, 16'h0});
		directed.push_back('{8'h00, slots(0, 0, 0, 0, 0, 0), 0, 0, 16'h0, 16'h0});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_report(directed[i]);

		cur_mods = '0;
		cur_keys = '0;
		for (item = 0; item < RANDOM_ITEMS; item++) begin
			idle_on = ((item / 60) % 3) != 2;
			if (item == HOLD_ITEM) begin
				s_tvalid <= 1'b0;
				while (pending_events.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				cur_mods = CODE_W'($urandom);
				for (i = 0; i < SLOTS; i++) cur_keys[i*CODE_W +: CODE_W] = CODE_W'($urandom);
			end else if (pick >= 20) begin
				if ($urandom_range(0, 9) < 3) begin
					if ($urandom_range(0, 1)) cur_mods = CODE_W'($urandom);
					else cur_mods[$urandom_range(0, CODE_W-1)] ^= 1'b1;
				end
				for (i = 0; i < SLOTS; i++) begin
					if ($urandom_range(0, 3) == 0) begin
						pick = $urandom_range(0, 9);
						if (pick < 4) cur_keys[i*CODE_W +: CODE_W] = '0;
						else if (pick < 8)
							cur_keys[i*CODE_W +: CODE_W] = CODE_W'($urandom_range(4, 11));
						else cur_keys[i*CODE_W +: CODE_W] = CODE_W'($urandom_range(0, 255));
					end
				end
			end
			row = '{cur_mods, cur_keys, 0, 0, 16'h0, 16'h0};
			send_report(row);
		end
		s_tvalid <= 1'b0;

		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("** keyboard_report_change_encoder: PASSED **");
		end else begin
			$display("** keyboard_report_change_encoder: FAILED **");
		end
		$finish;
	end

endmodule
